// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the stable priority ready queue.
// Holds the item kind and status codes and the sequencer state type.
package spq_pkg;

  typedef enum logic {
    KIND_INSERT   = 1'b0,
    KIND_DISPATCH = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_DSP_RD,
    S_DSP_CMP,
    S_DONE
  } state_e;

endpackage

// ===== hdl/spq_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the stable priority ready queue.
// Standalone; widths come from the instantiating level.
interface spq_in_if #(
  parameter int ID_WIDTH   = 8,
  parameter int PRIO_WIDTH = 3
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [ID_WIDTH-1:0]   process_id;
  logic [PRIO_WIDTH-1:0] prio;

  modport source (output valid, kind, process_id, prio, input ready);
  modport sink   (input valid, kind, process_id, prio, output ready);
endinterface

interface spq_out_if #(
  parameter int ID_WIDTH   = 8,
  parameter int PRIO_WIDTH = 3,
  parameter int CNT_WIDTH  = 5
);
  logic                  valid;
  logic                  ready;
  logic [ID_WIDTH-1:0]   out_id;
  logic [PRIO_WIDTH-1:0] out_prio;
  logic [1:0]            status;
  logic [CNT_WIDTH-1:0]  occupancy;

  modport source (output valid, out_id, out_prio, status, occupancy, input ready);
  modport sink   (input valid, out_id, out_prio, status, occupancy, output ready);
endinterface

// ===== hdl/stable_priority_ready_queue_core.sv =====
`timescale 1ns / 1ps
// Top level of the stable priority ready queue: entry memory and sequencer.
// Depends on spq_pkg and the channel interfaces in spq_if.sv.
//
//   channel | dir | payload                               | handshake
//   in_i    | in  | kind, process_id, prio                | valid/ready
//   out_o   | out | out_id, out_prio, status, occupancy   | valid/ready
//
// One entry memory (one write, one registered read port) is walked by a
// small sequencer. An insert moves entries back one slot each, from the tail
// toward the head, until it stops behind an entry of equal or better priority
// or reaches the head, then writes the new entry; a dispatch takes the head
// and moves every later entry forward; a flagged item only returns its status.
// Reset clears the state, count and output valid only; no clearing pass.
// The next item is taken while a finished result still waits in the output
// register; a second finished result holds the sequencer until that one leaves.
module stable_priority_ready_queue_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 8,
  parameter int PRIO_WIDTH  = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);
  import spq_pkg::*;

  localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
  localparam int IdxW  = $clog2(QUEUE_DEPTH);
  localparam int EntW  = ID_WIDTH + PRIO_WIDTH;
  localparam logic [CNT_WIDTH-1:0] Full = CNT_WIDTH'(QUEUE_DEPTH);
  localparam logic [CNT_WIDTH-1:0] One  = CNT_WIDTH'(1);

  state_e state_q, state_d;

  logic [CNT_WIDTH-1:0]  count_q, count_d;
  logic [CNT_WIDTH-1:0]  idx_q, idx_d;
  logic                  kind_q, kind_d;
  logic [ID_WIDTH-1:0]   id_q, id_d;
  logic [PRIO_WIDTH-1:0] prio_q, prio_d;
  logic [ID_WIDTH-1:0]   res_id_q, res_id_d;
  logic [PRIO_WIDTH-1:0] res_prio_q, res_prio_d;
  status_e               res_status_q, res_status_d;

  logic                  out_valid_q;
  logic [ID_WIDTH-1:0]   out_id_q;
  logic [PRIO_WIDTH-1:0] out_prio_q;
  logic [1:0]            out_status_q;
  logic [CNT_WIDTH-1:0]  out_occ_q;

  logic [EntW-1:0]       mem [QUEUE_DEPTH];
  logic [EntW-1:0]       rdata_q;
  logic [IdxW-1:0]       raddr;
  logic                  we;
  logic [IdxW-1:0]       waddr;
  logic [EntW-1:0]       wdata;

  logic                  in_xfer;
  logic                  load;
  logic                  ins_stop;
  logic                  dsp_last;
  logic [PRIO_WIDTH-1:0] rd_prio;
  logic [ID_WIDTH-1:0]   rd_id;
  logic [CNT_WIDTH-1:0]  idx_dec;
  logic [CNT_WIDTH-1:0]  idx_inc;

  // Shared decisions of the sequencer
  assign in_xfer  = in_i.valid && in_i.ready;
  assign load     = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign rd_prio  = rdata_q[EntW-1:ID_WIDTH];
  assign rd_id    = rdata_q[ID_WIDTH-1:0];
  assign idx_dec  = idx_q - One;
  assign idx_inc  = idx_q + One;
  assign ins_stop = (rd_prio <= prio_q);
  assign dsp_last = (idx_inc == count_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_i.kind == KIND_INSERT) begin
            if (count_q == Full) state_d = S_DONE;
            else if (count_q == '0) state_d = S_INS_PUT;
            else state_d = S_INS_RD;
          end else begin
            if (count_q == '0) state_d = S_DONE;
            else state_d = S_DSP_RD;
          end
        end
      end
      S_INS_RD:  state_d = S_INS_CMP;
      S_INS_CMP: begin
        if (ins_stop || idx_q == One) state_d = S_INS_PUT;
        else state_d = S_INS_RD;
      end
      S_INS_PUT: state_d = S_DONE;
      S_DSP_RD:  state_d = S_DSP_CMP;
      S_DSP_CMP: state_d = dsp_last ? S_DONE : S_DSP_RD;
      S_DONE:    if (load) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath controls and next values
  always_comb begin
    in_i.ready   = 1'b0;
    count_d      = count_q;
    idx_d        = idx_q;
    kind_d       = kind_q;
    id_d         = id_q;
    prio_d       = prio_q;
    res_id_d     = res_id_q;
    res_prio_d   = res_prio_q;
    res_status_d = res_status_q;
    raddr        = idx_q[IdxW-1:0];
    we           = 1'b0;
    waddr        = idx_q[IdxW-1:0];
    wdata        = rdata_q;
    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_xfer) begin
          kind_d       = in_i.kind;
          id_d         = in_i.process_id;
          prio_d       = in_i.prio;
          res_id_d     = '0;
          res_prio_d   = '0;
          res_status_d = ST_OK;
          if (in_i.kind == KIND_INSERT) begin
            idx_d = count_q;
            if (count_q == Full) res_status_d = ST_FULL;
          end else begin
            idx_d = '0;
            if (count_q == '0) res_status_d = ST_EMPTY;
          end
        end
      end
      // Read the entry just ahead of the hole
      S_INS_RD: raddr = idx_dec[IdxW-1:0];
      // Stop at an entry of equal or better priority, else move it back
      S_INS_CMP: begin
        if (!ins_stop) begin
          we    = 1'b1;
          waddr = idx_q[IdxW-1:0];
          wdata = rdata_q;
          idx_d = idx_dec;
        end
      end
      // Drop the new entry into the hole
      S_INS_PUT: begin
        we      = 1'b1;
        waddr   = idx_q[IdxW-1:0];
        wdata   = {prio_q, id_q};
        count_d = count_q + One;
      end
      S_DSP_RD: raddr = idx_q[IdxW-1:0];
      // Take the head, then advance every later entry by one slot
      S_DSP_CMP: begin
        if (idx_q == '0) begin
          res_id_d   = rd_id;
          res_prio_d = rd_prio;
        end else begin
          we    = 1'b1;
          waddr = idx_dec[IdxW-1:0];
          wdata = rdata_q;
        end
        idx_d = idx_inc;
        if (dsp_last) count_d = count_q - One;
      end
      default: ;
    endcase
  end

  // Entry memory with registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    kind_q       <= kind_d;
    id_q         <= id_d;
    prio_q       <= prio_d;
    res_id_q     <= res_id_d;
    res_prio_q   <= res_prio_d;
    res_status_q <= res_status_d;
    if (load) begin
      out_id_q     <= res_id_q;
      out_prio_q   <= res_prio_q;
      out_status_q <= res_status_q;
      out_occ_q    <= count_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_id    = out_id_q;
  assign out_o.out_prio  = out_prio_q;
  assign out_o.status    = out_status_q;
  assign out_o.occupancy = out_occ_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("entry count above queue depth");

  a_ins_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS_CMP |-> idx_q != '0 && idx_q <= count_q)
    else $error("insert walk index out of range");

  a_dsp_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DSP_CMP |-> idx_q < count_q)
    else $error("dispatch walk index out of range");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && res_status_q == ST_FULL |-> count_q == Full && kind_q == KIND_INSERT)
    else $error("full flag without a full queue");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS_PUT |=> count_q == $past(count_q) + One)
    else $error("insert did not grow the queue");
`endif

endmodule
